### rtl/us_pkg.sv
package us_pkg;

   // Job queue between the classifier and the byte serializer
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Last byte index of a replacement character (EF BF BD)
   localparam logic [1:0] REPL_LAST = 2'd2;

   // One job: up to four tokens, each a literal byte or one U+FFFD
   typedef struct packed {
      logic [2:0]      count;
      logic [3:0]      repl;
      logic [3:0][7:0] bytes;
   } job_type;

   function automatic logic is_cont(input logic [7:0] b);
      return b[7:6] == 2'b10;
   endfunction

   // Continuation bytes a lead needs; zero for ASCII, continuation bytes and invalid leads
   function automatic logic [1:0] cont_needed(input logic [7:0] c);
      logic [1:0] n;
      n = 2'd0;
      if (c[7:5] == 3'b110) begin
         n = 2'd1;
      end else if (c[7:4] == 4'b1110) begin
         n = 2'd2;
      end else if (c[7:3] == 5'b11110) begin
         n = 2'd3;
      end
      return n;
   endfunction

   // Check a complete sequence for overlong form, surrogate and range
   function automatic logic seq_valid(input logic [7:0] lead, input logic [7:0] c1,
                                      input logic [7:0] c2, input logic [7:0] last,
                                      input logic [1:0] need);
      logic [20:0] cp;
      logic        ok;
      cp = '0;
      ok = 1'b0;
      case (need)
         2'd1: begin
            cp = {10'd0, lead[4:0], last[5:0]};
            ok = cp >= 21'h00080;
         end
         2'd2: begin
            cp = {5'd0, lead[3:0], c1[5:0], last[5:0]};
            ok = (cp >= 21'h00800) && ((cp < 21'h0D800) || (cp > 21'h0DFFF));
         end
         2'd3: begin
            cp = {lead[2:0], c1[5:0], c2[5:0], last[5:0]};
            ok = (cp >= 21'h10000) && (cp <= 21'h10FFFF);
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      return ok;
   endfunction

   function automatic logic [7:0] repl_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'hEF;
         2'd1:    b = 8'hBF;
         default: b = 8'hBD;
      endcase
      return b;
   endfunction

endpackage

### rtl/utf8_sanitizer.sv
// UTF-8 sanitizer: raw bytes in, well-formed UTF-8 out.
// Request channel (req_): one raw byte per beat plus an end-of-text flag;
// a beat moves on a rising edge with req_valid high and req_stall low.
// Response channel (rsp_): one output byte per beat, a flag for bytes of an
// inserted U+FFFD (EF BF BD), and a flag on the last byte that an input
// beat causes. The consumer holds rsp_stall high to pause; the output
// register then holds its byte until taken.
// Throughput: one byte per cycle each way while every input byte gives one
// output byte and rsp_stall stays low. An input beat may give zero to
// twelve output bytes; the serializer emits one per cycle unless stalled,
// so long runs back-pressure the input through the four-entry job queue
// (req_stall is high when it is full). Path: an accepted byte's job is
// queued, then loaded into the output register on rsp_. Lead bytes waiting
// for continuations give no output until the sequence completes, breaks,
// or end of text flushes them.
// Reset (synchronous, active high) drops pending bytes, empties the queue
// and clears rsp_valid; no clearing pass is needed afterwards.
module utf8_sanitizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_replaced,
   output logic       rsp_last_of_run
);
   import us_pkg::*;

   logic    accept;
   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_head_valid;
   job_type front_job;
   job_type head_job;

   // Take a beat whenever the job queue has room
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   // Front: track the pending sequence and classify each byte into tokens
   us_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_in_byte),
      .end_of_text (req_end_of_text),
      .push        (q_push),
      .job         (front_job)
   );

   // Queue: decouple classification from serialization
   us_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (front_job),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_job   (head_job),
      .full       (q_full)
   );

   // Back: expand tokens into output bytes, one beat per cycle while rsp_stall is low
   us_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (q_head_valid),
      .head_job        (head_job),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_replaced    (rsp_replaced),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // Never write a job into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("job queue overflow");

   // A replacement byte is always one of EF, BF, BD
   a_repl_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_replaced |->
         rsp_out_byte == 8'hEF || rsp_out_byte == 8'hBF || rsp_out_byte == 8'hBD)
      else $error("bad replacement byte");

   // A run ending in a replacement ends on its final byte
   a_repl_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_replaced && rsp_last_of_run |-> rsp_out_byte == 8'hBD)
      else $error("run ends inside a replacement character");

   // Output is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule

### rtl/us_front.sv
module us_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       in_byte,
   input  logic             end_of_text,
   output logic             push,
   output us_pkg::job_type  job
);
   import us_pkg::*;

   logic [2:0][7:0] pend_ff, pend_in;
   logic [1:0]      pcnt_ff, pcnt_in;
   logic [1:0]      need;
   logic [1:0]      bneed;
   logic            keep_lead;

   assign need  = cont_needed(pend_ff[0]);
   assign bneed = cont_needed(in_byte);

   always_comb begin
      job       = '0;
      pend_in   = pend_ff;
      pcnt_in   = pcnt_ff;
      keep_lead = 1'b0;
      for (int i = 0; i < 3; i++) begin
         job.bytes[i] = (2'(i) < pcnt_ff) ? pend_ff[i] : in_byte;
      end
      job.bytes[3] = in_byte;
      if (pcnt_ff != 2'd0 && is_cont(in_byte)) begin
         if (pcnt_ff == need) begin
            // sequence complete: copy or replace as a whole
            pcnt_in = 2'd0;
            if (seq_valid(pend_ff[0], pend_ff[1], pend_ff[2], in_byte, need)) begin
               job.count = {1'b0, pcnt_ff} + 3'd1;
               job.repl  = 4'b0000;
            end else begin
               job.count = 3'd1;
               job.repl  = 4'b0001;
            end
         end else if (end_of_text) begin
            // cut off: lead and every continuation become U+FFFD
            pcnt_in   = 2'd0;
            job.count = {1'b0, pcnt_ff} + 3'd1;
            job.repl  = 4'b1111;
         end else begin
            pend_in[pcnt_ff] = in_byte;
            pcnt_in          = pcnt_ff + 2'd1;
         end
      end else begin
         // pending bytes of a broken sequence, stray continuations and invalid leads each become U+FFFD; ASCII passes
         job.count = {1'b0, pcnt_ff};
         job.repl  = 4'b1111;
         if (!in_byte[7]) begin
            job.repl[pcnt_ff] = 1'b0;
            job.count         = {1'b0, pcnt_ff} + 3'd1;
         end else if (bneed == 2'd0 || end_of_text) begin
            job.count = {1'b0, pcnt_ff} + 3'd1;
         end else begin
            keep_lead = 1'b1;
         end
         if (keep_lead) begin
            pend_in[0] = in_byte;
            pcnt_in    = 2'd1;
         end else begin
            pcnt_in = 2'd0;
         end
      end
   end

   assign push = accept && (job.count != 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         pcnt_ff <= 2'd0;
      end else if (accept) begin
         pcnt_ff <= pcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
   end

endmodule

### rtl/us_queue.sv
module us_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  us_pkg::job_type  push_job,
   input  logic             pop,
   output logic             head_valid,
   output us_pkg::job_type  head_job,
   output logic             full
);
   import us_pkg::*;

   job_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   assign head_valid = cnt_ff != '0;
   assign full       = cnt_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_job   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### rtl/us_back.sv
module us_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  us_pkg::job_type  head_job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_replaced,
   output logic             rsp_last_of_run
);
   import us_pkg::*;

   logic [1:0] tok_ff, tok_in;
   logic [1:0] sub_ff, sub_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       repl_ff;
   logic       last_ff;
   logic       is_repl;
   logic [7:0] cur_byte;
   logic       tok_end;
   logic       job_end;
   logic       load;

   assign is_repl  = head_job.repl[tok_ff];
   assign cur_byte = is_repl ? repl_byte(sub_ff) : head_job.bytes[tok_ff];
   assign tok_end  = !is_repl || (sub_ff == REPL_LAST);
   assign job_end  = tok_end && ({1'b0, tok_ff} == head_job.count - 3'd1);
   assign load     = head_valid && (!valid_ff || !rsp_stall);
   assign pop      = load && job_end;

   always_comb begin
      tok_in   = tok_ff;
      sub_in   = sub_ff;
      valid_in = valid_ff && rsp_stall;
      if (load) begin
         valid_in = 1'b1;
         if (tok_end) begin
            sub_in = 2'd0;
            tok_in = job_end ? 2'd0 : tok_ff + 2'd1;
         end else begin
            sub_in = sub_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff   <= 2'd0;
         sub_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         tok_ff   <= tok_in;
         sub_ff   <= sub_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= cur_byte;
         repl_ff <= is_repl;
         last_ff <= job_end;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_replaced    = repl_ff;
   assign rsp_last_of_run = last_ff;

endmodule
